FILE: hdl/i2a_pkg.sv
// i2a_pkg: shared constants and the pipeline stage type for the
// signed 32-bit to decimal ASCII converter. No dependencies.
package i2a_pkg;

   localparam int DIGIT_COUNT = 10;
   localparam int BIN_W       = 32;
   localparam int BCD_W       = DIGIT_COUNT * 4;
   localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [BIN_W-1:0] bin;
      logic [BCD_W-1:0] bcd;
   } stage_type;

endpackage

FILE: hdl/i2a_cell.sv
// i2a_cell: one shift-and-add-3 step of the binary to BCD chain.
// Depends on i2a_pkg.
module i2a_cell
   import i2a_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  stage_type stage_in,
   output stage_type stage_ff
);

   logic [BCD_W-1:0] bcd_adj;
   stage_type        step_in;

   always_comb begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (stage_in.bcd[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = stage_in.bcd[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = stage_in.bcd[d*4 +: 4];
         end
      end
      step_in.valid = stage_in.valid;
      step_in.neg   = stage_in.neg;
      step_in.bin   = {stage_in.bin[BIN_W-2:0], 1'b0};
      step_in.bcd   = {bcd_adj[BCD_W-2:0], stage_in.bin[BIN_W-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= step_in;
      end
   end

endmodule

FILE: hdl/i2a_serializer.sv
// i2a_serializer: turns one finished BCD word into an optional sign and digit items
// behind a registered output stage. Depends on i2a_pkg.
module i2a_serializer
   import i2a_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  stage_type  tail,
   output logic       take,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_ascii_char,
   output logic       rsp_last_char
);

   logic             busy_ff, busy_in;
   logic             neg_ff, neg_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic             finishing;

   assign out_free  = !valid_ff || !rsp_stall;
   assign finishing = busy_ff && out_free && !neg_ff && (cnt_ff == CNT_W'(1));
   assign take      = !busy_ff || finishing;

   always_comb begin
      busy_in  = busy_ff;
      neg_in   = neg_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = busy_ff;
         if (busy_ff) begin
            if (neg_ff) begin
               char_in = ASCII_MINUS;
               last_in = 1'b0;
               neg_in  = 1'b0;
            end else begin
               char_in = ASCII_ZERO + {4'd0, bcd_ff[BCD_W-1 -: 4]};
               last_in = (cnt_ff == CNT_W'(1));
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in  = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  busy_in = 1'b0;
               end
            end
         end
      end
      if (tail.valid && take) begin
         busy_in = 1'b1;
         neg_in  = tail.neg;
         bcd_in  = tail.bcd;
         cnt_in  = CNT_W'(DIGIT_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      neg_ff  <= neg_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

endmodule

FILE: hdl/int32_to_decimal_ascii.sv
// int32_to_decimal_ascii: 32 shift-and-add-3 cells in a chain, then a
// character serializer. Throughput is set by the one-character result channel;
// the chain holds up to 32 items in flight.
// Reset (synchronous) empties the chain, the serializer and the output; data
// registers are not reset.
// Depends on i2a_pkg, i2a_cell, i2a_serializer.
module int32_to_decimal_ascii
   import i2a_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [31:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_ascii_char,
   output logic              rsp_last_char
);

   stage_type  chain [0:BIN_W];
   logic       take;
   logic       adv;
   logic [BIN_W-1:0] raw;

   assign raw = req_value;
   assign adv = !chain[BIN_W].valid || take;
   assign req_stall = !adv;

   always_comb begin
      chain[0].valid = req_valid;
      chain[0].neg   = raw[BIN_W-1];
      chain[0].bin   = raw[BIN_W-1] ? (~raw + BIN_W'(1)) : raw;
      chain[0].bcd   = '0;
   end

   for (genvar g = 0; g < BIN_W; g++) begin : g_cell
      i2a_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .stage_in (chain[g]),
         .stage_ff (chain[g+1])
      );
   end

   i2a_serializer u_ser (
      .clock          (clock),
      .reset          (reset),
      .tail           (chain[BIN_W]),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

FILE: hdl/i2a_checker.sv
// i2a_checker: port-level assertions for int32_to_decimal_ascii, bound to
// the top level. Depends on i2a_pkg.
module i2a_checker
   import i2a_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_ascii_char,
   input logic       rsp_last_char
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ascii_char)
         && $stable(rsp_last_char))
      else $error("stalled item changed");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == ASCII_MINUS)
         || (rsp_ascii_char >= ASCII_ZERO && rsp_ascii_char <= ASCII_ZERO + 8'd9))
      else $error("character is neither sign nor digit");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii_char == ASCII_MINUS |-> !rsp_last_char)
      else $error("sign flagged as last");

   a_digit_after_minus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_ascii_char == ASCII_MINUS
         |=> !(rsp_valid && rsp_ascii_char == ASCII_MINUS))
      else $error("two signs in a row");

endmodule

bind int32_to_decimal_ascii i2a_checker u_i2a_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_last_char  (rsp_last_char)
);
